// File: src/mcfir_pkg.sv
// Shared constants, types and codes for the multichannel FIR filter.
`timescale 1ns / 1ps

package mcfir_pkg;

	localparam int CHANNELS      = 4;
	localparam int TAPS          = 32;
	localparam int SAMPLE_BITS   = 10;

	// fixed field widths of the item channels
	localparam int SAMPLE_FIELDS = 4;
	localparam int FIELD_W       = 10;
	localparam int ACTION_W      = 2;
	localparam int CHAN_IN_W     = 2;
	localparam int TAP_IN_W      = 5;
	localparam int WEIGHT_W      = 16;
	localparam int RAW_W         = 10;
	localparam int FILT_W        = 16;

	// accumulator keeps bits 30..0 of the tap sum; the result is bits 30..15
	localparam int OUT_LSB       = 15;
	localparam int ACC_W         = OUT_LSB + FILT_W;
	localparam int PROD_W        = WEIGHT_W + SAMPLE_BITS + 1;

	localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SADDR_W       = $clog2(TAPS);
	localparam int WADDR_W       = $clog2(CHANNELS * TAPS);
	localparam int ROW_W         = CHANNELS * SAMPLE_BITS;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SAMPLES = 2'd0,
		ACT_WEIGHT  = 2'd1,
		ACT_READ    = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN
	} state_t;

	// control that travels with each tap read through the MAC pipeline
	typedef struct packed {
		logic            vld;
		logic            first;
		logic            last;
		logic [CH_W-1:0] ch;
	} mac_ctl_t;

endpackage

// File: src/mcfir_in_if.sv
// Input item channel: valid/ready handshake with the action payload.
`timescale 1ns / 1ps

interface mcfir_in_if;
	import mcfir_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic [CHAN_IN_W-1:0]       channel;
	logic [FIELD_W-1:0]         sample_ch0;
	logic [FIELD_W-1:0]         sample_ch1;
	logic [FIELD_W-1:0]         sample_ch2;
	logic [FIELD_W-1:0]         sample_ch3;
	logic [TAP_IN_W-1:0]        tap_index;
	logic signed [WEIGHT_W-1:0] weight_value;

	modport source (
		output valid, action, channel, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		output tap_index, weight_value,
		input  ready
	);

	modport sink (
		input  valid, action, channel, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		input  tap_index, weight_value,
		output ready
	);

endinterface

// File: src/mcfir_out_if.sv
// Result channel: valid/ready handshake with the raw and filtered values.
`timescale 1ns / 1ps

interface mcfir_out_if;
	import mcfir_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [RAW_W-1:0]         raw_sample;
	logic signed [FILT_W-1:0] filtered_value;

	modport source (
		output valid, raw_sample, filtered_value,
		input  ready
	);

	modport sink (
		input  valid, raw_sample, filtered_value,
		output ready
	);

endinterface

// File: src/mcfir_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module mcfir_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  waddr,
	input  logic [W-1:0]                          wdata,
	input  logic                                  re,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  raddr,
	output logic [W-1:0]                          rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/mcfir_ctrl.sv
// Sequencer: clearing pass, sample/weight writes, write pointer and tap read issue.
`timescale 1ns / 1ps

module mcfir_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	mcfir_in_if.sink                   req,
	input  logic                       mac_busy,
	output logic                       s_we,
	output logic [mcfir_pkg::SADDR_W-1:0] s_waddr,
	output logic [mcfir_pkg::ROW_W-1:0]   s_wdata,
	output logic                       s_re,
	output logic [mcfir_pkg::SADDR_W-1:0] s_raddr,
	output logic                       w_we,
	output logic [mcfir_pkg::WADDR_W-1:0] w_waddr,
	output logic [mcfir_pkg::WEIGHT_W-1:0] w_wdata,
	output logic                       w_re,
	output logic [mcfir_pkg::WADDR_W-1:0] w_raddr,
	output mcfir_pkg::mac_ctl_t        issue
);
	import mcfir_pkg::*;

	localparam logic [SADDR_W-1:0] SLAST = SADDR_W'(TAPS - 1);
	localparam logic [WADDR_W-1:0] WLAST = WADDR_W'(CHANNELS * TAPS - 1);

	state_t               state_q;
	state_t               state_nxt;
	logic [WADDR_W-1:0]   clr_q;
	logic [SADDR_W-1:0]   wp_q;
	logic [SADDR_W-1:0]   k_q;
	logic [SADDR_W-1:0]   slot_q;
	logic [WADDR_W-1:0]   wa_q;
	logic [CH_W-1:0]      ch_q;

	logic                 beat;
	logic                 ch_ok;
	logic                 tap_ok;
	logic                 start_rd;
	logic [SADDR_W-1:0]   newest;
	logic [WADDR_W-1:0]   w_base;
	logic [WADDR_W-1:0]   w_addr_in;
	logic [FIELD_W-1:0]   fld [SAMPLE_FIELDS];
	logic [ROW_W-1:0]     row;

	assign req.ready = (state_q == ST_IDLE) && !mac_busy;
	assign beat      = req.valid && req.ready;
	assign ch_ok     = int'(req.channel) < CHANNELS;
	assign tap_ok    = int'(req.tap_index) < TAPS;
	assign start_rd  = beat && (req.action == ACT_READ) && ch_ok;
	assign newest    = (wp_q == '0) ? SLAST : wp_q - 1'b1;
	assign w_base    = WADDR_W'(int'(req.channel) * TAPS);
	assign w_addr_in = WADDR_W'(int'(req.channel) * TAPS + int'(req.tap_index));

	assign fld[0] = req.sample_ch0;
	assign fld[1] = req.sample_ch1;
	assign fld[2] = req.sample_ch2;
	assign fld[3] = req.sample_ch3;

	// one row holds the sample of every channel for one ring slot
	always_comb begin
		row = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (c < SAMPLE_FIELDS) begin
				row[c*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(fld[c]);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_we      = 1'b0;
		s_waddr   = wp_q;
		s_wdata   = row;
		w_we      = 1'b0;
		w_waddr   = w_addr_in;
		w_wdata   = req.weight_value;
		case (state_q)
			ST_CLEAR: begin
				s_we    = int'(clr_q) < TAPS;
				s_waddr = SADDR_W'(clr_q);
				s_wdata = '0;
				w_we    = 1'b1;
				w_waddr = clr_q;
				w_wdata = '0;
				if (clr_q == WLAST) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_we = beat && (req.action == ACT_SAMPLES);
				w_we = beat && (req.action == ACT_WEIGHT) && ch_ok && tap_ok;
				if (start_rd) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (k_q == SLAST) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	assign s_re        = (state_q == ST_RUN);
	assign w_re        = (state_q == ST_RUN);
	assign s_raddr     = slot_q;
	assign w_raddr     = wa_q;
	assign issue.vld   = (state_q == ST_RUN);
	assign issue.first = (k_q == '0);
	assign issue.last  = (k_q == SLAST);
	assign issue.ch    = ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wp_q    <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (s_we && (state_q != ST_CLEAR)) begin
				wp_q <= (wp_q == SLAST) ? '0 : wp_q + 1'b1;
			end
			if (start_rd) begin
				k_q <= '0;
			end else if (state_q == ST_RUN) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// walk the ring backward from the newest slot, weights forward from tap 0
	always_ff @(posedge clk) begin
		if (start_rd) begin
			slot_q <= newest;
			wa_q   <= w_base;
			ch_q   <= CH_W'(req.channel);
		end else if (state_q == ST_RUN) begin
			slot_q <= (slot_q == '0) ? SLAST : slot_q - 1'b1;
			wa_q   <= wa_q + 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_rd_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		start_rd |=> (issue.vld && issue.first))
		else $error("read beat did not start tap issue at tap 0");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(issue.vld && issue.last) |=> (state_q == ST_IDLE))
		else $error("sequencer stayed busy after last tap");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |-> !(s_we && w_we))
		else $error("sample and weight stores written by one beat");
`endif

endmodule

// File: src/mcfir_mac.sv
// Multiply-accumulate pipeline over the tap reads and the result register.
`timescale 1ns / 1ps

module mcfir_mac (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcfir_pkg::mac_ctl_t            issue,
	input  logic [mcfir_pkg::ROW_W-1:0]    s_rdata,
	input  logic [mcfir_pkg::WEIGHT_W-1:0] w_rdata,
	output logic                           busy,
	mcfir_out_if.source                    rsp
);
	import mcfir_pkg::*;

	mac_ctl_t                 ctl_s1;
	mac_ctl_t                 ctl_s2;
	logic [SAMPLE_BITS-1:0]   sample_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic [RAW_W-1:0]         raw_q;
	logic                     fin_q;
	logic                     out_vld_q;
	logic [RAW_W-1:0]         out_raw_q;
	logic signed [FILT_W-1:0] out_filt_q;
	logic                     xfer;

	assign sample_s1 = s_rdata[ctl_s1.ch*SAMPLE_BITS +: SAMPLE_BITS];
	assign xfer      = fin_q && (!out_vld_q || rsp.ready);
	assign busy      = ctl_s1.vld || ctl_s2.vld || fin_q;

	assign rsp.valid          = out_vld_q;
	assign rsp.raw_sample     = out_raw_q;
	assign rsp.filtered_value = out_filt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			fin_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			ctl_s1 <= issue;
			ctl_s2 <= ctl_s1;
			if (xfer) begin
				fin_q <= 1'b0;
			end else if (ctl_s2.vld && ctl_s2.last) begin
				fin_q <= 1'b1;
			end
			if (xfer) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// sum wraps at ACC_W bits: only bits 30..15 leave the block
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(w_rdata) * $signed({1'b0, sample_s1});
		if (ctl_s1.vld && ctl_s1.first) begin
			raw_q <= RAW_W'(sample_s1);
		end
		if (ctl_s2.vld) begin
			acc_q <= ctl_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
		if (xfer) begin
			out_raw_q  <= raw_q;
			out_filt_q <= acc_q[ACC_W-1:OUT_LSB];
		end
	end

`ifndef SYNTHESIS
	a_fin_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> (!ctl_s1.vld && !ctl_s2.vld))
		else $error("tap reads in flight while a result is pending");

	a_last_sets_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.vld && ctl_s2.last) |=> fin_q)
		else $error("last tap accumulated without a pending result");
`endif

endmodule

// File: src/multichannel_fir_filter_core.sv
// Four-channel 32-tap FIR filter core over a shared circular sample history.
// One item is accepted per cycle while no clearing pass or read is in progress.
// A read item runs one MAC per tap through the tap-read, product and accumulate registers;
// its result then moves to the output register once any earlier result there is taken,
// and only then is the next item accepted, set by the single tap-read port pair.
// After reset a clearing pass over all CHANNELS * TAPS weight addresses zeroes both stores, ready low.
`timescale 1ns / 1ps

module multichannel_fir_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	mcfir_in_if.sink    req,
	mcfir_out_if.source rsp
);
	import mcfir_pkg::*;

	logic                 s_we;
	logic [SADDR_W-1:0]   s_waddr;
	logic [ROW_W-1:0]     s_wdata;
	logic                 s_re;
	logic [SADDR_W-1:0]   s_raddr;
	logic [ROW_W-1:0]     s_rdata;
	logic                 w_we;
	logic [WADDR_W-1:0]   w_waddr;
	logic [WEIGHT_W-1:0]  w_wdata;
	logic                 w_re;
	logic [WADDR_W-1:0]   w_raddr;
	logic [WEIGHT_W-1:0]  w_rdata;
	mac_ctl_t             issue;
	logic                 mac_busy;

	mcfir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.mac_busy (mac_busy),
		.s_we     (s_we),
		.s_waddr  (s_waddr),
		.s_wdata  (s_wdata),
		.s_re     (s_re),
		.s_raddr  (s_raddr),
		.w_we     (w_we),
		.w_waddr  (w_waddr),
		.w_wdata  (w_wdata),
		.w_re     (w_re),
		.w_raddr  (w_raddr),
		.issue    (issue)
	);

	mcfir_ram #(
		.W (ROW_W),
		.D (TAPS)
	) u_hist_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	mcfir_ram #(
		.W (WEIGHT_W),
		.D (CHANNELS * TAPS)
	) u_wgt_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.re    (w_re),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	mcfir_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue),
		.s_rdata (s_rdata),
		.w_rdata (w_rdata),
		.busy    (mac_busy),
		.rsp     (rsp)
	);

endmodule

// File: verif/tb.sv
// Self-checking bench for the multichannel FIR core: directed rows, then randomized traffic.
`timescale 1ns / 1ps

module tb;
	import mcfir_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_ITEMS   = 1400;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic [ACTION_W-1:0]                     act;
		logic [CHAN_IN_W-1:0]                    ch;
		logic [SAMPLE_FIELDS-1:0][FIELD_W-1:0]   smp;
		logic [TAP_IN_W-1:0]                     tap;
		logic signed [WEIGHT_W-1:0]              wt;
		logic                                    chk;
		logic [RAW_W-1:0]                        exp_raw;
		logic signed [FILT_W-1:0]                exp_filt;
	} fir_item_t;

	typedef struct packed {
		logic [RAW_W-1:0]         raw;
		logic signed [FILT_W-1:0] filt;
	} fir_res_t;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_MOSTLY,
		RDY_PERIODIC
	} rdy_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	mcfir_in_if  req();
	mcfir_out_if rsp();

	multichannel_fir_filter_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [SAMPLE_BITS-1:0]     hist [CHANNELS][TAPS];
	logic signed [WEIGHT_W-1:0] wts  [CHANNELS][TAPS];
	logic [SADDR_W-1:0]         wptr;

	fir_res_t  pend_results[$];
	fir_item_t stim_rows[$];
	int        err_count = 0;
	int        burst_left = 0;
	bit        hold_rsp = 1'b0;

	function automatic void fir_apply(input fir_item_t it, output bit hit,
			output fir_res_t res);
		logic [SADDR_W-1:0] newest;
		logic [SADDR_W-1:0] slot;
		longint             acc;
		hit = 1'b0;
		res = '0;
		case (it.act)
			ACT_SAMPLES: begin
				for (int c = 0; c < CHANNELS; c++)
					hist[c][wptr] = it.smp[c];
				wptr = wptr + 1'b1;
			end
			ACT_WEIGHT: begin
				wts[it.ch][it.tap] = it.wt;
			end
			ACT_READ: begin
				newest = wptr - 1'b1;
				acc = 0;
				for (int k = 0; k < TAPS; k++) begin
					slot = newest - SADDR_W'(k);
					acc += longint'(wts[it.ch][k]) * longint'(hist[it.ch][slot]);
				end
				res.raw  = hist[it.ch][newest];
				res.filt = acc[ACC_W-1:OUT_LSB];
				hit = 1'b1;
			end
			default: ;
		endcase
	endfunction

	task automatic add_row(input logic [ACTION_W-1:0] act, input logic [CHAN_IN_W-1:0] ch,
			input logic [FIELD_W-1:0] s0, input logic [FIELD_W-1:0] s1,
			input logic [FIELD_W-1:0] s2, input logic [FIELD_W-1:0] s3,
			input logic [TAP_IN_W-1:0] tap, input logic signed [WEIGHT_W-1:0] wt,
			input logic chk, input logic [RAW_W-1:0] raw,
			input logic signed [FILT_W-1:0] filt);
		fir_item_t it;
		it.act = act;
		it.ch  = ch;
		it.smp = {s3, s2, s1, s0};
		it.tap = tap;
		it.wt  = wt;
		it.chk = chk;
		it.exp_raw  = raw;
		it.exp_filt = filt;
		stim_rows.push_back(it);
	endtask

	function automatic logic [FIELD_W-1:0] rand_sample();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(9))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2:       return -16'sd1;
			3:       return WEIGHT_W'(int'($urandom_range(255)) - 128);
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic fir_item_t rand_item();
		fir_item_t it;
		int        pick;
		pick = $urandom_range(99);
		if (pick < 40)
			it.act = ACT_SAMPLES;
		else if (pick < 72)
			it.act = ACT_WEIGHT;
		else if (pick < 95)
			it.act = ACT_READ;
		else
			it.act = ACT_UNUSED;
		it.ch  = CHAN_IN_W'($urandom);
		for (int c = 0; c < SAMPLE_FIELDS; c++)
			it.smp[c] = rand_sample();
		it.tap = TAP_IN_W'($urandom);
		it.wt  = rand_weight();
		it.chk = 1'b0;
		it.exp_raw  = '0;
		it.exp_filt = '0;
		return it;
	endfunction

	task automatic send_item(input fir_item_t it);
		bit       hit;
		fir_res_t res;
		@(negedge clk);
		req.valid        <= 1'b1;
		req.action       <= it.act;
		req.channel      <= it.ch;
		req.sample_ch0   <= it.smp[0];
		req.sample_ch1   <= it.smp[1];
		req.sample_ch2   <= it.smp[2];
		req.sample_ch3   <= it.smp[3];
		req.tap_index    <= it.tap;
		req.weight_value <= it.wt;
		do @(posedge clk); while (!req.ready);
		fir_apply(it, hit, res);
		if (hit) begin
			if (it.chk) begin
				res.raw  = it.exp_raw;
				res.filt = it.exp_filt;
			end
			pend_results.push_back(res);
		end
	endtask

	// bursts of random length, split by random gaps
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pend_results.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		fir_item_t it;
		int        n_sent;
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.action       = ACT_SAMPLES;
		req.channel      = '0;
		req.sample_ch0   = '0;
		req.sample_ch1   = '0;
		req.sample_ch2   = '0;
		req.sample_ch3   = '0;
		req.tap_index    = '0;
		req.weight_value = '0;
		wptr = '0;
		for (int c = 0; c < CHANNELS; c++)
			for (int k = 0; k < TAPS; k++) begin
				hist[c][k] = '0;
				wts[c][k]  = '0;
			end

		// zeroed stores read back zero; a single full-negative tap gives exactly -1023
		add_row(ACT_READ,    2'd0, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sd0,    1, 10'd0,   16'sd0);
		add_row(ACT_READ,    2'd3, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sd0,    1, 10'd0,   16'sd0);
		add_row(ACT_UNUSED,  2'd2, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF,
			5'd31, -16'sd1,   0, 10'd0,   16'sd0);
		add_row(ACT_WEIGHT,  2'd1, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sh8000, 0, 10'd0,   16'sd0);
		add_row(ACT_SAMPLES, 2'd0, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF,
			5'd0,  16'sd0,    0, 10'd0,   16'sd0);
		add_row(ACT_READ,    2'd1, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sd0,    1, 10'h3FF, -16'sd1023);
		add_row(ACT_WEIGHT,  2'd0, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sh7FFF, 0, 10'd0,   16'sd0);
		add_row(ACT_WEIGHT,  2'd0, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd31, 16'sh7FFF, 0, 10'd0,   16'sd0);
		add_row(ACT_READ,    2'd0, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sd0,    0, 10'd0,   16'sd0);
		add_row(ACT_SAMPLES, 2'd0, 10'h155, 10'h2AA, 10'h155, 10'h2AA,
			5'd0,  16'sd0,    0, 10'd0,   16'sd0);
		add_row(ACT_WEIGHT,  2'd2, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd1,  -16'sd1,   0, 10'd0,   16'sd0);
		add_row(ACT_WEIGHT,  2'd3, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd15, 16'sh5555, 0, 10'd0,   16'sd0);
		add_row(ACT_SAMPLES, 2'd3, 10'h2AA, 10'h155, 10'h2AA, 10'h155,
			5'd21, 16'sh2AAA, 0, 10'd0,   16'sd0);
		add_row(ACT_READ,    2'd2, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sd0,    0, 10'd0,   16'sd0);
		add_row(ACT_READ,    2'd3, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sd0,    0, 10'd0,   16'sd0);
		add_row(ACT_WEIGHT,  2'd1, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd16, 16'sh8000, 0, 10'd0,   16'sd0);
		add_row(ACT_SAMPLES, 2'd0, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sd0,    0, 10'd0,   16'sd0);
		add_row(ACT_READ,    2'd0, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sd0,    0, 10'd0,   16'sd0);
		add_row(ACT_UNUSED,  2'd1, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sd0,    0, 10'd0,   16'sd0);
		add_row(ACT_READ,    2'd1, 10'd0,   10'd0,   10'd0,   10'd0,
			5'd0,  16'sd0,    0, 10'd0,   16'sd0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[i]) begin
			send_item(stim_rows[i]);
			pace();
		end
		drain();

		n_sent = 0;
		while (n_sent < RANDOM_ITEMS) begin
			it = rand_item();
			if (n_sent == 300) begin
				// long result hold-off with a read in flight and the sender still pushing
				hold_rsp = 1'b1;
				it.act = ACT_READ;
			end
			if (n_sent == 800)
				drain();
			send_item(it);
			if (it.act != ACT_UNUSED)
				n_sent++;
			pace();
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : receiver
		rdy_mode_t mode;
		int        cnt;
		mode = RDY_ALWAYS;
		cnt = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_rsp = 1'b0;
			end else begin
				cnt++;
				if (cnt % 50 == 0)
					mode = rdy_mode_t'($urandom_range(3));
				case (mode)
					RDY_ALWAYS:   rsp.ready <= 1'b1;
					RDY_COIN:     rsp.ready <= 1'($urandom_range(1));
					RDY_MOSTLY:   rsp.ready <= ($urandom_range(3) != 0);
					RDY_PERIODIC: rsp.ready <= ((cnt % 7) < 3);
					default:      rsp.ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_rsp
		fir_res_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pend_results.size() == 0) begin
				$error("result beat with nothing pending: raw_sample %0d filtered_value %0d",
					rsp.raw_sample, $signed(rsp.filtered_value));
				err_count++;
			end else begin
				want = pend_results.pop_front();
				if (rsp.raw_sample !== want.raw) begin
					$error("raw_sample: expected %0d, got %0d", want.raw, rsp.raw_sample);
					err_count++;
				end
				if (rsp.filtered_value !== want.filt) begin
					$error("filtered_value: expected %0d, got %0d",
						$signed(want.filt), $signed(rsp.filtered_value));
					err_count++;
				end
			end
		end
	end

	// end the run if neither side moves a beat for too long
	always @(posedge clk) begin : watchdog
		int idle_cycles;
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule

// File: multichannel_fir_filter_core.f
src/mcfir_pkg.sv
src/mcfir_in_if.sv
src/mcfir_out_if.sv
src/mcfir_ram.sv
src/mcfir_ctrl.sv
src/mcfir_mac.sv
src/multichannel_fir_filter_core.sv
verif/tb.sv
